>>> src/svf_pkg.sv
package svf_pkg;

    // Coefficient formats (unsigned fixed point).
    localparam int FREQ_WIDTH = 15;
    localparam int FREQ_FRAC  = 14;
    localparam int DAMP_WIDTH = 16;
    localparam int DAMP_FRAC  = 12;
    localparam int CFG_WIDTH  = 16;

    localparam logic [DAMP_WIDTH-1:0] DAMP_RESET = 16'd4096;

    // The serial multiplier walks the widest coefficient one bit per cycle.
    localparam int COEF_WIDTH = DAMP_WIDTH;
    localparam int CNT_WIDTH  = $clog2(COEF_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(COEF_WIDTH - 1);

    typedef enum logic [0:0] {
        CFG_FREQ = 1'b0,
        CFG_DAMP = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAMP_MUL,
        S_HIGH,
        S_BAND_MUL,
        S_BAND,
        S_LOW_MUL,
        S_LOW,
        S_DONE
    } t_state;

endpackage

>>> src/svf_in_if.sv
interface svf_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_first;

    modport source (output valid, output sample_in, output clear_first, input ready);
    modport sink   (input valid, input sample_in, input clear_first, output ready);
endinterface

>>> src/svf_out_if.sv
interface svf_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] low_out;
    logic signed [SAMPLE_WIDTH-1:0] high_out;
    logic signed [SAMPLE_WIDTH-1:0] band_out;

    modport source (output valid, output low_out, output high_out, output band_out,
                    input ready);
    modport sink   (input valid, input low_out, input high_out, input band_out,
                    output ready);
endinterface

>>> src/state_variable_filter.sv
// Channel    Dir  Payload                              Handshake
// i_smp      in   sample_in, clear_first               valid / ready
// o_res      out  low_out, high_out, band_out          valid / ready
// i_cfg_*    in   i_cfg_idx, i_cfg_data                i_cfg_we, no back-pressure
//
// Each sample runs from its request to a loaded result register as three
// dependent multiplies on one shift-and-add multiplier at one coefficient bit
// per cycle, each followed by a round, add and clamp step.
// Reset clears the filter state, the control and the coefficients to their defaults.
// A stalled result holds in the output register; the next request is taken as soon
// as the filter is idle, even while that result still waits.
module state_variable_filter
    import svf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    svf_in_if.sink               i_smp,
    svf_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    localparam int SW = STATE_WIDTH;
    localparam int CW = COEF_WIDTH;
    localparam int PW = SW + CW;                  // full product
    localparam int QW = PW - (DAMP_FRAC - 1);     // product before the final round bit
    localparam int VW = QW + 2;                   // sums before clamping

    localparam logic signed [VW-1:0] ST_MAX = {{(VW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [VW-1:0] ST_MIN = {{(VW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] SM_MAX =
        {{(SW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SM_MIN =
        {{(SW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat_state(input logic signed [VW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > ST_MAX) begin
            r = ST_MAX[SW-1:0];
        end else if (v < ST_MIN) begin
            r = ST_MIN[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [SW-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v > SM_MAX) begin
            r = SM_MAX[SAMPLE_WIDTH-1:0];
        end else if (v < SM_MIN) begin
            r = SM_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [FREQ_WIDTH-1:0]          r_freq;
    logic [DAMP_WIDTH-1:0]          r_damp;
    logic signed [SW-1:0]           r_band;
    logic signed [SW-1:0]           r_low;
    logic signed [SW-1:0]           r_high;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SW-1:0]           r_acc;
    logic [CW-1:0]                  r_lsb;
    logic [CW-1:0]                  r_csh;
    logic [CNT_WIDTH-1:0]           r_cnt;
    logic                           r_oval;
    logic signed [SAMPLE_WIDTH-1:0] r_low_o;
    logic signed [SAMPLE_WIDTH-1:0] r_high_o;
    logic signed [SAMPLE_WIDTH-1:0] r_band_o;

    logic                  w_accept;
    logic                  w_mul_step;
    logic                  w_out_load;
    logic                  w_idle;
    logic signed [SW-1:0]  w_mcand;
    logic signed [SW:0]    w_msum;
    logic signed [PW-1:0]  w_prod;
    logic signed [QW-1:0]  w_q;
    logic signed [QW:0]    w_q1;
    logic signed [QW-1:0]  w_rnd;
    logic signed [VW-1:0]  w_rnd_e;
    logic signed [VW-1:0]  w_base;
    logic signed [VW-1:0]  w_v;
    logic signed [SW-1:0]  w_sat;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept) n_state = S_DAMP_MUL;
            S_DAMP_MUL: if (r_cnt == CNT_LAST) n_state = S_HIGH;
            S_HIGH:     n_state = S_BAND_MUL;
            S_BAND_MUL: if (r_cnt == CNT_LAST) n_state = S_BAND;
            S_BAND:     n_state = S_LOW_MUL;
            S_LOW_MUL:  if (r_cnt == CNT_LAST) n_state = S_LOW;
            S_LOW:      n_state = S_DONE;
            S_DONE:     if (!r_oval || o_res.ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_idle     = 1'b0;
        w_mul_step = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:                            w_idle = 1'b1;
            S_DAMP_MUL, S_BAND_MUL, S_LOW_MUL: w_mul_step = 1'b1;
            S_DONE:                            w_out_load = !r_oval || o_res.ready;
            S_HIGH, S_BAND, S_LOW:             ;
            default:                           ;
        endcase
    end

    assign i_smp.ready    = w_idle;
    assign w_accept       = i_smp.valid && w_idle;
    assign o_res.valid    = r_oval;
    assign o_res.low_out  = r_low_o;
    assign o_res.high_out = r_high_o;
    assign o_res.band_out = r_band_o;

    // The damping product multiplies band; the frequency products take high, then band.
    assign w_mcand = (r_state == S_BAND_MUL) ? r_high : r_band;
    assign w_msum  = {r_acc[SW-1], r_acc} + (r_csh[0] ? {w_mcand[SW-1], w_mcand} : '0);

    // Round half up: shift to keep one bit below the result, add one, drop that bit.
    assign w_prod = {r_acc, r_lsb};
    assign w_q    = (r_state == S_HIGH) ? QW'(w_prod >>> (DAMP_FRAC - 1))
                                        : QW'(w_prod >>> (FREQ_FRAC - 1));
    assign w_q1   = {w_q[QW-1], w_q} + (QW+1)'(1);
    assign w_rnd  = w_q1[QW:1];
    assign w_rnd_e = {{2{w_rnd[QW-1]}}, w_rnd};

    always_comb begin
        unique case (r_state)
            S_HIGH:  w_base = {{(VW-SAMPLE_WIDTH){r_x[SAMPLE_WIDTH-1]}}, r_x}
                              - {{(VW-SW){r_low[SW-1]}}, r_low};
            S_BAND:  w_base = {{(VW-SW){r_band[SW-1]}}, r_band};
            default: w_base = {{(VW-SW){r_low[SW-1]}}, r_low};
        endcase
    end

    assign w_v   = (r_state == S_HIGH) ? w_base - w_rnd_e : w_base + w_rnd_e;
    assign w_sat = sat_state(w_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_freq  <= '0;
            r_damp  <= DAMP_RESET;
            r_band  <= '0;
            r_low   <= '0;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_FREQ: r_freq <= i_cfg_data[FREQ_WIDTH-1:0];
                    CFG_DAMP: r_damp <= i_cfg_data[DAMP_WIDTH-1:0];
                    default:  ;
                endcase
            end

            if (w_accept && i_smp.clear_first) begin
                r_band <= '0;
                r_low  <= '0;
            end
            if (r_state == S_BAND) begin
                r_band <= w_sat;
            end
            if (r_state == S_LOW) begin
                r_low <= w_sat;
            end

            if (w_mul_step) begin
                r_cnt <= r_cnt + CNT_WIDTH'(1);
            end else begin
                r_cnt <= '0;
            end

            if (w_out_load) begin
                r_oval <= 1'b1;
            end else if (o_res.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= i_smp.sample_in;
            r_csh <= r_damp;
            r_acc <= '0;
        end
        if (w_mul_step) begin
            r_acc <= w_msum[SW:1];
            r_lsb <= {w_msum[0], r_lsb[CW-1:1]};
            r_csh <= {1'b0, r_csh[CW-1:1]};
        end
        if (r_state == S_HIGH) begin
            r_high <= w_sat;
        end
        if (r_state == S_HIGH || r_state == S_BAND) begin
            r_csh <= {{(CW-FREQ_WIDTH){1'b0}}, r_freq};
            r_acc <= '0;
        end
        if (w_out_load) begin
            r_low_o  <= sat_sample(r_low);
            r_high_o <= sat_sample(r_high);
            r_band_o <= sat_sample(r_band);
        end
    end

    a_rose_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_oval) |-> $past(r_state) == S_DONE)
        else $error("result valid rose outside the done step");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("bit counter not cleared while idle");

    a_damp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAMP_MUL && r_cnt == CNT_LAST) |=> (r_state == S_HIGH))
        else $error("damping multiply did not end after the last coefficient bit");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> (r_state == S_DAMP_MUL && r_cnt == '0))
        else $error("accepted request did not start the damping multiply");

endmodule
